FILE: hw/rtl/pat_section_program_table_assert.svh
// ----------------------------------------------------------------------------
// PAT section program table assertion macros
// Concurrent checks that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef PAT_SECTION_PROGRAM_TABLE_ASSERT_SVH
`define PAT_SECTION_PROGRAM_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define PAT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pat assertion failed");

`define PAT_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("pat forbidden condition");

`else

`define PAT_ASSERT(lbl, clk, rst, prop)

`define PAT_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

FILE: hw/rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// PAT package
// Types, constants and codes shared by the PAT section program table.
// ----------------------------------------------------------------------------
package pat_pkg;

   localparam int MAX_PROGRAMS      = 64;
   localparam int MAX_SECTION_BYTES = 1024;
   localparam int ADDR_W            = $clog2(MAX_PROGRAMS);
   localparam int CNT_W             = $clog2(MAX_PROGRAMS + 1);
   localparam int POS_W             = $clog2(MAX_SECTION_BYTES + 1);

   localparam int FIRST_ENTRY   = 8;
   localparam int ENTRY_BYTES   = 4;
   localparam int ENTRY_LSB_W   = $clog2(ENTRY_BYTES);
   localparam int COMMIT_START  = FIRST_ENTRY + 5;
   localparam int TSID_POS      = 4;
   localparam int WINDOW_W      = 48;
   localparam logic [4:0] PID_HIGH_MASK = 5'h1f;

   localparam logic FUNC_BYTE   = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [15:0] service_id;
   } pat_req_type;

   typedef struct packed {
      logic        kind;
      logic [12:0] pmt_pid;
      logic        found;
      logic [6:0]  entry_count;
      logic        table_updated;
      logic        overflow;
      logic        section_ok;
   } pat_rsp_type;

   typedef struct packed {
      logic [15:0] prog;
      logic [12:0] pid;
   } pat_entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      pat_entry_type     entry;
   } pat_wr_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic        found;
      logic [12:0] pid;
   } pat_srch_type;

endpackage

FILE: hw/rtl/pat_table.sv
// ----------------------------------------------------------------------------
// PAT entry table
// Entry memory with one write port and a sequential first-match search.
// ----------------------------------------------------------------------------
module pat_table (
   input  logic                        clock,
   input  logic                        reset,
   input  pat_pkg::pat_wr_type         wr,
   input  logic                        start,
   input  logic [15:0]                 sid,
   input  logic [pat_pkg::CNT_W-1:0]   count,
   input  logic                        take,
   output pat_pkg::pat_srch_type       srch
);
   import pat_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CMP, ST_DONE} state_type;

   state_type     state_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [15:0]   sid_ff;
   logic          found_ff;
   logic [12:0]   pid_ff;
   pat_entry_type rd_ff;
   pat_entry_type mem [MAX_PROGRAMS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      rd_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  idx_ff   <= '0;
                  sid_ff   <= sid;
                  found_ff <= 1'b0;
                  pid_ff   <= '0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (idx_ff < count) begin
                  state_ff <= ST_CMP;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_CMP: begin
               if (rd_ff.prog == sid_ff) begin
                  found_ff <= 1'b1;
                  pid_ff   <= rd_ff.pid;
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff   <= idx_ff + CNT_W'(1);
                  state_ff <= ST_READ;
               end
            end
            ST_DONE: begin
               if (take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign srch.busy  = (state_ff != ST_IDLE);
   assign srch.done  = (state_ff == ST_DONE);
   assign srch.found = found_ff;
   assign srch.pid   = pid_ff;

endmodule

FILE: hw/rtl/pat_section_program_table.sv
// ----------------------------------------------------------------------------
// PAT section program table
// Parses PAT section bytes into a program table and answers PMT PID lookups.
// ----------------------------------------------------------------------------
//   channel   dir  payload        beat
//   req_      in   pat_req_type   section byte or lookup
//   rsp_      out  pat_rsp_type   end-of-section status or lookup answer
//
// A section byte writes at most one table entry.
// A lookup holds ready low while it reads and compares the stored entries in
// order, through a registered entry memory read, up to a hit or the last entry.
// Reset clears control state only; the table needs no clearing pass.
// Requests stall while a lookup runs or a response is held unaccepted.
// ----------------------------------------------------------------------------
module pat_section_program_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pat_pkg::pat_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pat_pkg::pat_rsp_type rsp_data
);
   import pat_pkg::*;
   `include "pat_section_program_table_assert.svh"

   logic [POS_W-1:0]    byte_position_ff, byte_position_in;
   logic [15:0]         stream_id_ff, stream_id_in;
   logic                stream_id_valid_ff, stream_id_valid_in;
   logic                refilling_ff, refilling_in;
   logic [WINDOW_W-1:0] byte_window_ff, byte_window_in;
   logic [CNT_W-1:0]    stored_count_ff, stored_count_in;
   logic                dropped_flag_ff, dropped_flag_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pat_rsp_type         rsp_data_ff, rsp_data_in;

   pat_wr_type   wr;
   pat_srch_type srch;
   logic         start;
   logic         take;
   logic         req_fire;
   logic         out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !srch.busy && out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      logic [POS_W-1:0] pos_diff;
      logic [15:0]      prog;
      pos_diff           = byte_position_ff - POS_W'(COMMIT_START);
      prog               = '0;
      byte_position_in   = byte_position_ff;
      stream_id_in       = stream_id_ff;
      stream_id_valid_in = stream_id_valid_ff;
      refilling_in       = refilling_ff;
      byte_window_in     = byte_window_ff;
      stored_count_in    = stored_count_ff;
      dropped_flag_in    = dropped_flag_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_data_in        = rsp_data_ff;
      wr                 = '0;
      start              = 1'b0;
      take               = 1'b0;

      if (req_fire && req_data.func == FUNC_LOOKUP) begin
         start = 1'b1;
      end

      if (req_fire && req_data.func == FUNC_BYTE) begin
         if (byte_position_ff < POS_W'(MAX_SECTION_BYTES)) begin
            byte_window_in = {byte_window_ff[WINDOW_W-9:0], req_data.data_byte};
            if (byte_position_ff == POS_W'(TSID_POS) &&
                (!stream_id_valid_ff || byte_window_in[15:0] != stream_id_ff)) begin
               stream_id_in       = byte_window_in[15:0];
               stream_id_valid_in = 1'b1;
               stored_count_in    = '0;
               dropped_flag_in    = 1'b0;
               refilling_in       = 1'b1;
            end
            prog = byte_window_in[47:32];
            if (refilling_in && byte_position_ff >= POS_W'(COMMIT_START) &&
                pos_diff[ENTRY_LSB_W-1:0] == '0 && prog != '0) begin
               if (stored_count_in < CNT_W'(MAX_PROGRAMS)) begin
                  wr.en         = 1'b1;
                  wr.addr       = stored_count_in[ADDR_W-1:0];
                  wr.entry.prog = prog;
                  wr.entry.pid  = {byte_window_in[28:24] & PID_HIGH_MASK,
                                   byte_window_in[23:16]};
                  stored_count_in = stored_count_in + CNT_W'(1);
               end else begin
                  dropped_flag_in = 1'b1;
               end
            end
            byte_position_in = byte_position_ff + POS_W'(1);
         end
         if (req_data.last_byte) begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.kind          = KIND_STATUS;
            rsp_data_in.pmt_pid       = '0;
            rsp_data_in.found         = 1'b0;
            rsp_data_in.entry_count   = 7'(stored_count_in);
            rsp_data_in.table_updated = refilling_in;
            rsp_data_in.overflow      = dropped_flag_in;
            rsp_data_in.section_ok    = 1'b1;
            byte_position_in          = '0;
            byte_window_in            = '0;
            refilling_in              = 1'b0;
            dropped_flag_in           = 1'b0;
         end
      end

      if (srch.done && out_free) begin
         take                      = 1'b1;
         rsp_valid_in              = 1'b1;
         rsp_data_in.kind          = KIND_LOOKUP;
         rsp_data_in.pmt_pid       = srch.pid;
         rsp_data_in.found         = srch.found;
         rsp_data_in.entry_count   = 7'(stored_count_ff);
         rsp_data_in.table_updated = 1'b0;
         rsp_data_in.overflow      = 1'b0;
         rsp_data_in.section_ok    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff   <= '0;
         stream_id_ff       <= '0;
         stream_id_valid_ff <= 1'b0;
         refilling_ff       <= 1'b0;
         byte_window_ff     <= '0;
         stored_count_ff    <= '0;
         dropped_flag_ff    <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         byte_position_ff   <= byte_position_in;
         stream_id_ff       <= stream_id_in;
         stream_id_valid_ff <= stream_id_valid_in;
         refilling_ff       <= refilling_in;
         byte_window_ff     <= byte_window_in;
         stored_count_ff    <= stored_count_in;
         dropped_flag_ff    <= dropped_flag_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   pat_table u_table (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .start (start),
      .sid   (req_data.service_id),
      .count (stored_count_ff),
      .take  (take),
      .srch  (srch)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PAT_ASSERT_NEVER(a_count_range, clock, reset, stored_count_ff > CNT_W'(MAX_PROGRAMS))
   `PAT_ASSERT(a_lookup_busy, clock, reset,
      (req_fire && req_data.func == FUNC_LOOKUP) |=> srch.busy)
   `PAT_ASSERT(a_status_form, clock, reset,
      (rsp_valid_ff && rsp_data_ff.kind == KIND_STATUS) |->
      (rsp_data_ff.section_ok && !rsp_data_ff.found))
   `PAT_ASSERT(a_window_start, clock, reset,
      (byte_position_ff == '0) |-> (byte_window_ff == '0))

endmodule

FILE: test/pat_table_checker.sv
// ----------------------------------------------------------------------------
// PAT table checker
// Watches both channels of the PAT section program table, keeps its own
// model of the section parser and program table, and compares every
// response beat field by field with the oldest predicted answer.
// ----------------------------------------------------------------------------
module pat_table_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  pat_pkg::pat_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pat_pkg::pat_rsp_type rsp_data,
   output int                   error_count,
   output int                   pending_count,
   output int                   status_count,
   output int                   lookup_count,
   output int                   hit_count,
   output int                   refill_count,
   output int                   overflow_count
);
   import pat_pkg::*;

   logic [10:0] sec_pos;
   logic [15:0] cur_tsid;
   logic        tsid_seen;
   logic        refill_on;
   logic [47:0] window;
   logic [15:0] prog_tab [MAX_PROGRAMS];
   logic [12:0] pid_tab [MAX_PROGRAMS];
   logic [6:0]  n_stored;
   logic        lost_entry;

   pat_rsp_type pending_answers [$];
   pat_rsp_type want;

   int errors    = 0;
   int statuses  = 0;
   int lookups   = 0;
   int hits      = 0;
   int refills   = 0;
   int overflows = 0;

   function automatic int field_bad(string name, logic [15:0] exp_val, logic [15:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         return 1;
      end
      return 0;
   endfunction

   task automatic track_req_beat(input pat_req_type beat);
      pat_rsp_type ans;
      logic [15:0] prog;
      ans = '0;
      if (beat.func == FUNC_LOOKUP) begin
         ans.kind        = KIND_LOOKUP;
         ans.entry_count = n_stored;
         for (int i = 0; i < MAX_PROGRAMS; i++) begin
            if (i < n_stored && prog_tab[i] == beat.service_id) begin
               ans.pmt_pid = pid_tab[i];
               ans.found   = 1'b1;
               break;
            end
         end
         lookups++;
         if (ans.found) hits++;
         pending_answers.push_back(ans);
      end else begin
         if (sec_pos < MAX_SECTION_BYTES) begin
            window = {window[39:0], beat.data_byte};
            if (sec_pos == TSID_POS && (!tsid_seen || window[15:0] != cur_tsid)) begin
               cur_tsid   = window[15:0];
               tsid_seen  = 1'b1;
               n_stored   = '0;
               lost_entry = 1'b0;
               refill_on  = 1'b1;
            end
            if (refill_on && sec_pos >= COMMIT_START &&
                ((int'(sec_pos) - COMMIT_START) % ENTRY_BYTES) == 0) begin
               prog = window[47:32];
               if (prog != 16'h0000) begin
                  if (n_stored < MAX_PROGRAMS) begin
                     prog_tab[n_stored[5:0]] = prog;
                     pid_tab[n_stored[5:0]]  = {window[28:24] & PID_HIGH_MASK,
                                                window[23:16]};
                     n_stored++;
                  end else begin
                     lost_entry = 1'b1;
                  end
               end
            end
            sec_pos++;
         end
         if (beat.last_byte) begin
            ans.kind          = KIND_STATUS;
            ans.entry_count   = n_stored;
            ans.table_updated = refill_on;
            ans.overflow      = lost_entry;
            ans.section_ok    = 1'b1;
            statuses++;
            if (refill_on) refills++;
            if (lost_entry) overflows++;
            pending_answers.push_back(ans);
            sec_pos    = '0;
            window     = '0;
            refill_on  = 1'b0;
            lost_entry = 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sec_pos    = '0;
         cur_tsid   = '0;
         tsid_seen  = 1'b0;
         refill_on  = 1'b0;
         window     = '0;
         n_stored   = '0;
         lost_entry = 1'b0;
         pending_answers.delete();
      end else begin
         if (req_valid && req_ready) track_req_beat(req_data);
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               $error("response beat with no answer pending: %p", rsp_data);
               errors++;
            end else begin
               want = pending_answers.pop_front();
               errors += field_bad("kind", 16'(want.kind), 16'(rsp_data.kind));
               errors += field_bad("pmt_pid", 16'(want.pmt_pid), 16'(rsp_data.pmt_pid));
               errors += field_bad("found", 16'(want.found), 16'(rsp_data.found));
               errors += field_bad("entry_count", 16'(want.entry_count),
                                   16'(rsp_data.entry_count));
               errors += field_bad("table_updated", 16'(want.table_updated),
                                   16'(rsp_data.table_updated));
               errors += field_bad("overflow", 16'(want.overflow), 16'(rsp_data.overflow));
               errors += field_bad("section_ok", 16'(want.section_ok),
                                   16'(rsp_data.section_ok));
            end
         end
      end
      error_count    <= errors;
      pending_count  <= pending_answers.size();
      status_count   <= statuses;
      lookup_count   <= lookups;
      hit_count      <= hits;
      refill_count   <= refills;
      overflow_count <= overflows;
   end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// PAT section program table testbench
// Feeds directed and random PAT sections, broken sections and lookups into
// the table with random idle bursts on both channels; the checker predicts
// and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
   import pat_pkg::*;

   localparam int ITEM_TARGET  = 1850;
   localparam int CALM_AFTER   = 1650;
   localparam int LIMIT_CYCLES = 1500000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   pat_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   pat_rsp_type rsp_data;

   bit          idle_en    = 1'b0;
   int          hold_left  = 0;
   int          items_sent = 0;
   logic [7:0]  sec_bytes [$];
   logic [15:0] last_tsid  = '0;
   bit          long_done  = 1'b0;

   int error_count, pending_count, status_count, lookup_count;
   int hit_count, refill_count, overflow_count;

   always #6 clock = ~clock;

   pat_section_program_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   pat_table_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .status_count   (status_count),
      .lookup_count   (lookup_count),
      .hit_count      (hit_count),
      .refill_count   (refill_count),
      .overflow_count (overflow_count)
   );

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
         hold_left <= $urandom_range(1, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_beat(input pat_req_type beat);
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (idle_en && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_lookup(input logic [15:0] sid);
      pat_req_type beat;
      beat.func       = FUNC_LOOKUP;
      beat.data_byte  = 8'($urandom);
      beat.last_byte  = 1'($urandom);
      beat.service_id = sid;
      send_beat(beat);
   endtask

   task automatic send_byte(input logic [7:0] d, input logic last);
      pat_req_type beat;
      beat.func       = FUNC_BYTE;
      beat.data_byte  = d;
      beat.last_byte  = last;
      beat.service_id = 16'($urandom);
      send_beat(beat);
   endtask

   // hold the sender until every pending answer has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [15:0] pick_prog();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      if (r < 10) return 16'($urandom_range(1, 8));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_sid();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 16'hFFFF;
      if (r < 5) return 16'($urandom_range(0, 8));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_tsid();
      int r;
      r = $urandom_range(0, 5);
      if (r == 0) last_tsid = 16'h0000;
      else if (r == 1) last_tsid = 16'hFFFF;
      else if (r == 2) last_tsid = 16'($urandom);
      else if (r == 3) last_tsid = 16'($urandom_range(1, 3));
      return last_tsid;
   endfunction

   task automatic build_pat(input logic [15:0] tsid, input int n_prog);
      logic [15:0] prog;
      logic [12:0] pid;
      logic [11:0] len;
      len = 12'(9 + 4 * n_prog);
      sec_bytes.delete();
      sec_bytes.push_back(8'($urandom));
      sec_bytes.push_back({4'hB, len[11:8]});
      sec_bytes.push_back(len[7:0]);
      sec_bytes.push_back(tsid[15:8]);
      sec_bytes.push_back(tsid[7:0]);
      sec_bytes.push_back(8'($urandom));
      sec_bytes.push_back(8'($urandom));
      sec_bytes.push_back(8'($urandom));
      repeat (n_prog) begin
         prog = pick_prog();
         pid  = 13'($urandom);
         sec_bytes.push_back(prog[15:8]);
         sec_bytes.push_back(prog[7:0]);
         sec_bytes.push_back({3'($urandom), pid[12:8]});
         sec_bytes.push_back(pid[7:0]);
      end
      repeat (4) sec_bytes.push_back(8'($urandom));
   endtask

   task automatic play_section(input int lookup_odds);
      foreach (sec_bytes[i]) begin
         if (lookup_odds > 0 && $urandom_range(1, lookup_odds) == 1) send_lookup(pick_sid());
         send_byte(sec_bytes[i], i == sec_bytes.size() - 1);
      end
   endtask

   initial begin
      int pick;
      int n;
      repeat (11) @(posedge clock);
      reset   <= 1'b0;
      idle_en <= 1'b1;

      send_lookup(16'hFFFF);
      send_byte(8'hFF, 1'b1);
      sec_bytes = '{8'h00, 8'hB0, 8'h0D};
      play_section(0);
      sec_bytes = '{8'h00, 8'hB0, 8'h11, 8'h00, 8'h00, 8'hC1, 8'h00, 8'h00,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hE0, 8'h10,
                    8'h12, 8'h34, 8'h56, 8'h78};
      play_section(0);
      send_lookup(16'hFFFF);
      send_lookup(16'h0000);
      hold_until_drained();

      while (items_sent < ITEM_TARGET) begin
         idle_en <= (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (!long_done && items_sent > 400) begin
            long_done = 1'b1;
            last_tsid = last_tsid + 16'd1;
            build_pat(last_tsid, 255);
            play_section(0);
         end else if (pick < 55) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
            build_pat(pick_tsid(), n);
            play_section(50);
         end else if (pick < 70) begin
            if ($urandom_range(0, 3) == 0) hold_until_drained();
            repeat ($urandom_range(1, 3)) send_lookup(pick_sid());
         end else if (pick < 80) begin
            n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 40);
            sec_bytes.delete();
            repeat (n) sec_bytes.push_back(8'($urandom));
            play_section(20);
         end else if (pick < 82) begin
            last_tsid = last_tsid + 16'd1;
            build_pat(last_tsid, $urandom_range(62, 70));
            play_section(40);
         end else begin
            build_pat(pick_tsid(), $urandom_range(1, 8));
            play_section(6);
         end
      end

      req_valid <= 1'b0;
      idle_en   <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (150) @(posedge clock);
      $display("tb_top: %0d beats, %0d section statuses (%0d refills, %0d with dropped entries)",
               items_sent, status_count, refill_count, overflow_count);
      $display("tb_top: %0d lookups, %0d of them hits, one over-length section",
               lookup_count, hit_count);
      if (error_count == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/pat_pkg.sv
hw/rtl/pat_table.sv
hw/rtl/pat_section_program_table.sv
test/pat_table_checker.sv
test/tb_top.sv
